// File: rtl/wmix_pkg.sv
// Shared types, constants and field layout for the four-voice stereo wave mixer.
`default_nettype none
package wmix_pkg;

  localparam int DEF_VOICES  = 4;
  localparam int FRAME_SPAN  = 32768;

  localparam int FRAME_W  = 15;
  localparam int SEED_W   = 32;
  localparam int SAMPLE_W = 8;
  localparam int REG_W    = 57;
  localparam int DATA_W   = 64;
  localparam int VAL_W    = 9;

  localparam int SEED_L_OFS = 1;
  localparam int SEED_R_OFS = 17;
  localparam int MIX_BIAS   = 128;
  localparam int SAMPLE_MAX = 255;

  // Pipeline depth of one voice and of one cell (voice plus sum register).
  localparam int VOICE_LAT = 13;
  localparam int CELL_LAT  = VOICE_LAT + 1;

  localparam logic [31:0] HASH_C1  = 32'h7feb352d;
  localparam logic [31:0] HASH_C2  = 32'h846ca68b;
  localparam logic [31:0] SEED_MUL = 32'h9e3779b9;

  // floor(x/25) == (x*DIV25_K) >> DIV25_SH for x < 4096
  localparam logic [11:0] DIV25_K  = 12'd2622;
  localparam int          DIV25_SH = 16;

  // Wave codes; anything else plays the smooth sine.
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;
  localparam logic [2:0] WAVE_PNOISE = 3'd5;

  typedef struct packed {
    logic [SEED_W-1:0]  noise_seed;
    logic [FRAME_W-1:0] frame;
  } beat_t;

endpackage
`default_nettype wire

// File: rtl/wmix_voice.sv
// One voice: phase, wave shaping, hashed noise and volume scaling, fully pipelined.
`default_nettype none
module wmix_voice import wmix_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [REG_W-1:0]         cfg,
  input  logic [FRAME_W-1:0]       frame,
  input  logic [SEED_W-1:0]        seed,
  output logic signed [VAL_W-1:0]  value
);

  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = 16 / DIV_STEPS;
  localparam int NN_DLY     = 6;
  localparam int HS_DLY     = DIV_STAGES - 1;

  logic        active;
  logic [2:0]  wave;
  logic [4:0]  vol;
  logic [31:0] step;
  logic [15:0] dwell;
  logic [15:0] dvs;
  logic        is_noise;
  logic        is_pnoise;
  logic        is_shape;

  assign active    = cfg[0];
  assign wave      = cfg[3:1];
  assign vol       = cfg[8:4];
  assign step      = cfg[40:9];
  assign dwell     = cfg[56:41];
  assign dvs       = (dwell == 16'd0) ? 16'd1 : dwell;
  assign is_noise  = (wave == WAVE_NOISE);
  assign is_pnoise = (wave == WAVE_PNOISE);
  assign is_shape  = (wave == WAVE_SQUARE) || (wave == WAVE_SAW) || (wave == WAVE_TRI);

  // Two restoring-division steps; quotient bits shift in as dividend bits shift out.
  function automatic logic [31:0] div2(input logic [15:0] rem, input logic [15:0] nq,
                                       input logic [15:0] d);
    logic [16:0] r;
    logic [15:0] rr;
    logic [15:0] q;
    rr = rem;
    q  = nq;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r = {rr, q[15]};
      q = {q[14:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
      rr = r[15:0];
    end
    return {rr, q};
  endfunction

  // stage 1
  logic [31:0] ph1;
  logic [31:0] hs1;
  always_ff @(posedge clk) begin
    if (en) begin
      ph1 <= 32'({17'd0, frame} * step);
      hs1 <= seed * SEED_MUL;
    end
  end

  // frame / dwell, stages 1..8
  logic [15:0] drem [DIV_STAGES];
  logic [15:0] dnum [DIV_STAGES];
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) {drem[j], dnum[j]} <= div2(16'd0, {1'b0, frame}, dvs);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) {drem[j], dnum[j]} <= div2(drem[j-1], dnum[j-1], dvs);
      end
    end
  end

  // carry seed product and phase bucket alongside the divider
  logic [31:0] hsd [HS_DLY];
  logic [11:0] pbd [HS_DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      hsd[0] <= hs1;
      pbd[0] <= ph1[31:20];
      for (int k = 1; k < HS_DLY; k++) begin
        hsd[k] <= hsd[k-1];
        pbd[k] <= pbd[k-1];
      end
    end
  end

  logic [31:0] bucket;
  logic [31:0] key;
  logic [31:0] hx1;
  logic [31:0] h1;
  logic [31:0] h2;
  assign bucket = is_pnoise ? {20'd0, pbd[HS_DLY-1]} : {16'd0, dnum[DIV_STAGES-1]};
  assign key    = bucket + hsd[HS_DLY-1];
  assign hx1    = h1 ^ (h1 >> 15);

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= (key ^ (key >> 16)) * HASH_C1;
      h2 <= hx1 * HASH_C2;
    end
  end

  // shapes from phase
  logic signed [34:0] t;
  logic        [34:0] tmag;
  logic        [39:0] saw_p;
  logic        [40:0] tri_p;
  logic        [8:0]  s3;
  logic signed [VAL_W-1:0] oth;

  always_comb begin
    if (!ph1[31]) begin
      t = $signed({1'b0, ph1, 2'b00}) - 35'sh1_0000_0000;
    end else begin
      t = 35'sh3_0000_0000 - $signed({1'b0, ph1, 2'b00});
    end
    tmag  = (t < 0) ? 35'(-t) : 35'(t);
    saw_p = {1'b0, ph1, 7'd0} + {2'b0, ph1, 6'd0};
    tri_p = {1'b0, ph1, 8'd0} + {2'b0, ph1, 7'd0};
    s3    = tri_p[40:32];
    case (wave)
      WAVE_SQUARE: oth = ph1[31] ? -9'sd96 : 9'sd96;
      WAVE_SAW:    oth = $signed({1'b0, saw_p[39:32]}) - 9'sd96;
      WAVE_TRI:    oth = ph1[31] ? (9'sd288 - $signed(s3)) : ($signed(s3) - 9'sd96);
      default:     oth = '0;
    endcase
  end

  logic [16:0]             m2, m3;
  logic                    neg2, neg3, neg4;
  logic signed [VAL_W-1:0] oth2, oth3, oth4;
  logic [33:0]             msq3;
  logic [33:0]             pf;
  logic [50:0]             p4;
  logic [51:0]             s5;
  logic signed [VAL_W-1:0] sine_raw;

  assign pf       = 34'h3_0000_0000 - msq3;
  assign s5       = {p4, 1'b0} + {1'b0, p4};
  assign sine_raw = neg4 ? -$signed({1'b0, s5[51:44]}) : $signed({1'b0, s5[51:44]});

  logic signed [VAL_W-1:0] nnd [NN_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      m2     <= tmag[32:16];
      neg2   <= t[34];
      oth2   <= oth;
      m3     <= m2;
      neg3   <= neg2;
      oth3   <= oth2;
      msq3   <= {17'd0, m2} * {17'd0, m2};
      p4     <= {34'd0, m3} * {17'd0, pf};
      neg4   <= neg3;
      oth4   <= oth3;
      nnd[0] <= is_shape ? oth4 : sine_raw;
      for (int k = 1; k < NN_DLY; k++) nnd[k] <= nnd[k-1];
    end
  end

  // raw, volume, divide by 25
  logic signed [VAL_W-1:0] raw11;
  logic signed [14:0]      prod;
  logic                    neg12;
  logic [11:0]             mag12;
  logic [23:0]             q24;
  logic [7:0]              q8;

  assign prod = raw11 * $signed({1'b0, vol});
  assign q24  = {12'd0, mag12} * {12'd0, DIV25_K};
  assign q8   = q24[DIV25_SH+7:DIV25_SH];

  always_ff @(posedge clk) begin
    if (en) begin
      raw11 <= (is_noise || is_pnoise) ? $signed({1'b0, h2[31:24]} - 9'd128) : nnd[NN_DLY-1];
      neg12 <= prod[14];
      mag12 <= prod[14] ? 12'(-prod) : 12'(prod);
      if (!active) value <= '0;
      else if (neg12) value <= -$signed({1'b0, q8});
      else value <= $signed({1'b0, q8});
    end
  end

endmodule
`default_nettype wire

// File: rtl/wmix_cell.sv
// One stereo voice slot of the mixer chain: adds its left and right voice to the running sums.
`default_nettype none
module wmix_cell import wmix_pkg::*; #(
  parameter int IDX   = 0,
  parameter int SUM_W = 13
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [REG_W-1:0]        lcfg,
  input  logic [REG_W-1:0]        rcfg,
  input  logic                    in_valid,
  input  beat_t                   in_beat,
  input  logic signed [SUM_W-1:0] in_lsum,
  input  logic signed [SUM_W-1:0] in_rsum,
  output logic                    out_valid,
  output beat_t                   out_beat,
  output logic signed [SUM_W-1:0] out_lsum,
  output logic signed [SUM_W-1:0] out_rsum
);

  logic [SEED_W-1:0]       lseed, rseed;
  logic signed [VAL_W-1:0] lval, rval;

  assign lseed = in_beat.noise_seed + SEED_W'(SEED_L_OFS + IDX);
  assign rseed = in_beat.noise_seed + SEED_W'(SEED_R_OFS + IDX);

  wmix_voice u_left (
    .clk   (clk),
    .en    (en),
    .cfg   (lcfg),
    .frame (in_beat.frame),
    .seed  (lseed),
    .value (lval)
  );

  wmix_voice u_right (
    .clk   (clk),
    .en    (en),
    .cfg   (rcfg),
    .frame (in_beat.frame),
    .seed  (rseed),
    .value (rval)
  );

  logic                    vd [VOICE_LAT];
  beat_t                   bd [VOICE_LAT];
  logic signed [SUM_W-1:0] ld [VOICE_LAT];
  logic signed [SUM_W-1:0] rd [VOICE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VOICE_LAT; k++) vd[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vd[0] <= in_valid;
      for (int k = 1; k < VOICE_LAT; k++) vd[k] <= vd[k-1];
      out_valid <= vd[VOICE_LAT-1];
    end
  end

  // travel with the voice pipeline, then pick up this slot's values
  always_ff @(posedge clk) begin
    if (en) begin
      bd[0] <= in_beat;
      ld[0] <= in_lsum;
      rd[0] <= in_rsum;
      for (int k = 1; k < VOICE_LAT; k++) begin
        bd[k] <= bd[k-1];
        ld[k] <= ld[k-1];
        rd[k] <= rd[k-1];
      end
      out_beat <= bd[VOICE_LAT-1];
      out_lsum <= ld[VOICE_LAT-1] + SUM_W'(lval);
      out_rsum <= rd[VOICE_LAT-1] + SUM_W'(rval);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid))
    else $error("cell valid changed while stalled");

  a_hold_sum: assert property (@(posedge clk) disable iff (rst)
    (!en && out_valid) |=> ($stable(out_lsum) && $stable(out_rsum)))
    else $error("cell sums changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("cell holds a beat right after reset");

endmodule
`default_nettype wire

// File: rtl/four_voice_stereo_wave_mixer.sv
// Top level: voice registers, APB port, cell chain and output stage.
// Four-voice stereo wave mixer. Each input beat (frame index, seed base) yields one
// beat holding an unsigned 8-bit left and right sample, 128 being silence. The block
// takes one beat per clock; a beat goes through a chain of VOICES cells, each holding
// one left and one right voice pipeline plus the sum register, then the output register.
// The whole chain holds while the output beat waits. Voice registers are 57 bits, at
// byte address 8*i over the 64-bit APB port: left voices first, then right voices;
// reset turns all voices off.
`default_nettype none
module four_voice_stereo_wave_mixer import wmix_pkg::*; #(
  parameter int VOICES = DEF_VOICES,
  localparam int NREG  = 2 * VOICES,
  localparam int IW    = $clog2(NREG),
  localparam int AW    = IW + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,  // frame_index[14:0], noise_seed[46:15], zero
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,  // left_sample[7:0], right_sample[15:8]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AW-1:0]     paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SUM_W = VAL_W + $clog2(VOICES + 1) + 1;

  logic [REG_W-1:0] regs [NREG];
  logic [IW-1:0]    cfg_idx;
  logic             cfg_hit;

  assign cfg_idx = paddr[AW-1:3];
  assign cfg_hit = ({1'b0, cfg_idx} < (IW+1)'(NREG));
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? DATA_W'(regs[cfg_idx]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NREG; k++) regs[k] <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      regs[cfg_idx] <= pwdata[REG_W-1:0];
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic                    vc [VOICES+1];
  beat_t                   bc [VOICES+1];
  logic signed [SUM_W-1:0] lc [VOICES+1];
  logic signed [SUM_W-1:0] rc [VOICES+1];

  assign vc[0]            = s_tvalid;
  assign bc[0].frame      = s_tdata[FRAME_W-1:0] & FRAME_W'(FRAME_SPAN - 1);
  assign bc[0].noise_seed = s_tdata[FRAME_W+SEED_W-1:FRAME_W];
  assign lc[0]            = SUM_W'(MIX_BIAS);
  assign rc[0]            = SUM_W'(MIX_BIAS);

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    wmix_cell #(
      .IDX   (i),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .lcfg      (regs[i]),
      .rcfg      (regs[VOICES+i]),
      .in_valid  (vc[i]),
      .in_beat   (bc[i]),
      .in_lsum   (lc[i]),
      .in_rsum   (rc[i]),
      .out_valid (vc[i+1]),
      .out_beat  (bc[i+1]),
      .out_lsum  (lc[i+1]),
      .out_rsum  (rc[i+1])
    );
  end

  function automatic logic [SAMPLE_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    if (v < 0) return '0;
    if (v > SUM_W'(SAMPLE_MAX)) return SAMPLE_W'(SAMPLE_MAX);
    return v[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vc[VOICES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) m_tdata <= {sat(rc[VOICES]), sat(lc[VOICES])};
  end

endmodule
`default_nettype wire
